// ===== rtl/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared constants, codes and types of the nearest-neighbour label vote.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

    localparam int DIMENSIONS = 14;
    localparam int NEIGHBOURS = 5;

    localparam int IDX_W   = 4;
    localparam int COORD_W = 17;
    localparam int CODE_W  = 16;
    localparam int DIFF_W  = 18;
    localparam int MAG_W   = 17;
    localparam int SQ_W    = 34;
    localparam int DIST_W  = 38;
    localparam int CNT_W   = 3;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SCALE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_CODE = CFG_IDX_W'(1);

    localparam logic [CODE_W-1:0] QUANT_SCALE_RESET  = CODE_W'(10000);
    localparam logic [CODE_W-1:0] MISSING_CODE_RESET = CODE_W'(65535);

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_ELEM   = 2'd2,
        OP_REPORT = 2'd3
    } opcode_t;

    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic              insert;
        logic [DIST_W-1:0] sqdist;
        logic              label;
    } cand_t;

endpackage

`default_nettype wire

// ===== rtl/knn_top5_label_vote.sv =====
// ----------------------------------------------------------------------------
// knn_top5_label_vote
// Five-nearest-neighbour search over 14-dimensional quantized vectors with a
// vote on the fraud labels of the kept neighbours.
//
// Input stream (s_): opcode in s_tuser, last element of a candidate in
// s_tlast. Start clears the list, load writes one query coordinate, element
// adds one squared difference, report requests a result.
// Result stream (m_): one result per report with fraud count, slots filled
// and fifth distance.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; index 0 is
// quant_scale, index 1 missing_code.
// Throughput: one request per cycle while no stall holds s_tready low. A
// report's result passes the input register, square, accumulate and list stages.
// A stall holds the whole pipeline only when a report reaches the result
// register while the previous result still waits; other requests keep
// flowing behind a waiting result.
// Reset (aresetn low, synchronous): query cleared, list empty, registers at
// quant_scale 10000 and missing_code 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_top5_label_vote
    import knn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // coord_index[3:0], query_value[20:4], element_code[36:21],
    // candidate_label[37], zero[39:38]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // fraud_total[2:0], neighbours_found[5:3], fifth_distance[43:6], zero[47:44]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CODE_W-1:0] quant_scale_reg;
    logic [CODE_W-1:0] missing_code_reg;
    logic              hold;
    cand_t             cand;

    assign cfg_ready = 1'b1;
    assign s_tready  = !hold;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_scale_reg  <= QUANT_SCALE_RESET;
            missing_code_reg <= MISSING_CODE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUANT_SCALE:  quant_scale_reg  <= cfg_data;
                CFG_MISSING_CODE: missing_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    knn_dist u_dist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .hold         (hold),
        .in_op        (opcode_t'(s_tuser)),
        .in_idx       (s_tdata[3:0]),
        .in_query     (s_tdata[20:4]),
        .in_code      (s_tdata[36:21]),
        .in_label     (s_tdata[37]),
        .in_last      (s_tlast),
        .quant_scale  (quant_scale_reg),
        .missing_code (missing_code_reg),
        .cand         (cand)
    );

    knn_list u_list (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cand     (cand),
        .m_tready (m_tready),
        .hold     (hold),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/knn_dist.sv =====
// ----------------------------------------------------------------------------
// knn_dist
// Input register, query store, element square and distance accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_dist
    import knn_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    input  wire logic                      hold,
    input  wire opcode_t                   in_op,
    input  wire logic [IDX_W-1:0]          in_idx,
    input  wire logic signed [COORD_W-1:0] in_query,
    input  wire logic [CODE_W-1:0]         in_code,
    input  wire logic                      in_label,
    input  wire logic                      in_last,
    input  wire logic [CODE_W-1:0]         quant_scale,
    input  wire logic [CODE_W-1:0]         missing_code,
    output cand_t                          cand
);

    logic                      v1_reg;
    opcode_t                   op1_reg;
    logic [IDX_W-1:0]          idx1_reg;
    logic signed [COORD_W-1:0] qv1_reg;
    logic [CODE_W-1:0]         code1_reg;
    logic                      lab1_reg;
    logic                      last1_reg;

    logic signed [COORD_W-1:0] query_reg [DIMENSIONS];

    logic                      v2_reg;
    opcode_t                   op2_reg;
    logic                      add2_reg;
    logic [SQ_W-1:0]           sq2_reg;
    logic                      lab2_reg;
    logic                      last2_reg;

    logic [DIST_W-1:0]         partial_reg;
    logic [DIST_W-1:0]         partial_next;

    logic                      c_valid_reg;
    opcode_t                   c_op_reg;
    logic                      c_insert_reg;
    logic [DIST_W-1:0]         c_dist_reg;
    logic                      c_label_reg;

    logic                      in_range1;
    logic signed [COORD_W-1:0] q_sel;
    logic signed [DIFF_W-1:0]  elem_val;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  neg_diff;
    logic [MAG_W-1:0]          mag;
    logic [SQ_W-1:0]           sq_next;
    logic [DIST_W-1:0]         sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (!hold) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!hold) begin
            op1_reg   <= in_op;
            idx1_reg  <= in_idx;
            qv1_reg   <= in_query;
            code1_reg <= in_code;
            lab1_reg  <= in_label;
            last1_reg <= in_last;
        end
    end

    assign in_range1 = idx1_reg < IDX_W'(DIMENSIONS);
    assign q_sel     = in_range1 ? query_reg[idx1_reg] : '0;
    assign elem_val  = (code1_reg == missing_code) ? -$signed({2'b00, quant_scale})
                                                   : $signed({2'b00, code1_reg});
    assign diff      = $signed({q_sel[COORD_W-1], q_sel}) - elem_val;
    assign neg_diff  = -diff;
    assign mag       = diff[DIFF_W-1] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
    assign sq_next   = {{(SQ_W-MAG_W){1'b0}}, mag} * {{(SQ_W-MAG_W){1'b0}}, mag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIMENSIONS; i++) begin
                query_reg[i] <= '0;
            end
        end else if (!hold && v1_reg && op1_reg == OP_LOAD && in_range1) begin
            query_reg[idx1_reg] <= qv1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (!hold) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!hold) begin
            op2_reg   <= op1_reg;
            add2_reg  <= v1_reg && op1_reg == OP_ELEM && in_range1;
            sq2_reg   <= sq_next;
            lab2_reg  <= lab1_reg;
            last2_reg <= last1_reg;
        end
    end

    assign sum_next = partial_reg + (add2_reg ? {{(DIST_W-SQ_W){1'b0}}, sq2_reg} : '0);

    always_comb begin
        partial_next = partial_reg;
        if (v2_reg) begin
            case (op2_reg)
                OP_START: partial_next = '0;
                OP_ELEM:  partial_next = last2_reg ? '0 : sum_next;
                default:  partial_next = partial_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            c_valid_reg <= 1'b0;
        end else if (!hold) begin
            partial_reg <= partial_next;
            c_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!hold) begin
            c_op_reg     <= op2_reg;
            c_insert_reg <= op2_reg == OP_ELEM && last2_reg;
            c_dist_reg   <= sum_next;
            c_label_reg  <= lab2_reg;
        end
    end

    assign cand = '{valid:  c_valid_reg,
                    op:     c_op_reg,
                    insert: c_insert_reg,
                    sqdist: c_dist_reg,
                    label:  c_label_reg};

endmodule

`default_nettype wire

// ===== rtl/knn_list.sv =====
// ----------------------------------------------------------------------------
// knn_list
// Sorted five-slot neighbour list, label vote and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_list
    import knn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cand_t                 cand,
    input  wire logic                  m_tready,
    output logic                       hold,
    output logic                       m_tvalid,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [DIST_W-1:0]     dist_reg  [NEIGHBOURS];
    logic [DIST_W-1:0]     dist_next [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] label_reg;
    logic [NEIGHBOURS-1:0] label_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [NEIGHBOURS-1:0] lt;
    logic                  advance;
    logic                  do_insert;
    logic                  do_report;
    logic [CNT_W-1:0]      frauds;
    logic [DIST_W-1:0]     fifth;

    assign hold      = cand.valid && cand.op == OP_REPORT && m_valid_reg && !m_tready;
    assign advance   = cand.valid && !hold;
    assign do_insert = advance && cand.op == OP_ELEM && cand.insert && (|lt);
    assign do_report = advance && cand.op == OP_REPORT;

    for (genvar g = 0; g < NEIGHBOURS; g++) begin : g_slot
        assign lt[g] = (CNT_W'(g) >= fill_reg) || (cand.sqdist < dist_reg[g]);
        if (g == 0) begin : g_head
            assign dist_next[g]  = lt[g] ? cand.sqdist : dist_reg[g];
            assign label_next[g] = lt[g] ? cand.label : label_reg[g];
        end else begin : g_tail
            assign dist_next[g]  = !lt[g] ? dist_reg[g]
                                 : (lt[g-1] ? dist_reg[g-1] : cand.sqdist);
            assign label_next[g] = !lt[g] ? label_reg[g]
                                 : (lt[g-1] ? label_reg[g-1] : cand.label);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (advance && cand.op == OP_START) begin
            fill_next = '0;
        end else if (do_insert && fill_reg < CNT_W'(NEIGHBOURS)) begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_comb begin
        frauds = '0;
        for (int i = 0; i < NEIGHBOURS; i++) begin
            frauds = frauds + CNT_W'(label_reg[i] && (CNT_W'(i) < fill_reg));
        end
    end

    assign fifth = (fill_reg >= CNT_W'(NEIGHBOURS)) ? dist_reg[NEIGHBOURS-1] : '1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_insert) begin
            for (int i = 0; i < NEIGHBOURS; i++) begin
                dist_reg[i] <= dist_next[i];
            end
            label_reg <= label_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_report) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_report) begin
            m_data_reg <= {{(OUT_DATA_W-DIST_W-2*CNT_W){1'b0}}, fifth, fill_reg, frauds};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(NEIGHBOURS))
        else $error("fill count above list size");

    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        hold |-> m_valid_reg && cand.op == OP_REPORT)
        else $error("stall without a waiting result");

    a_start_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cand.op == OP_START) |=> fill_reg == '0)
        else $error("list not emptied by start");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_insert && fill_reg < CNT_W'(NEIGHBOURS)) |=>
        fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("insert into partial list did not grow it");
`endif

endmodule

`default_nettype wire
